// ----- rtl/gis_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gimbal idle scan sequencer package
// Shared widths, register codes, reset values and the configuration struct.
// ----------------------------------------------------------------------------
package gis_pkg;

   localparam int ANGLE_BITS_DEF = 32;
   localparam int TIME_BITS_DEF  = 32;

   localparam int RATE_BITS      = 32;
   localparam int LIMIT_BITS     = 30;
   localparam int DELAY_BITS     = 32;
   localparam int STEP_BITS      = 20;
   localparam int FRAC_BITS      = 16;
   localparam int SPEED_BITS     = 33;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ENABLE,
      CSR_YAW_RATE,
      CSR_PITCH_RATE,
      CSR_PITCH_LIMIT,
      CSR_ACT_DELAY,
      CSR_MAX_STEP
   } csr_index_type;

   typedef struct packed {
      logic                  enable;
      logic [RATE_BITS-1:0]  yaw_rate;
      logic [RATE_BITS-1:0]  pitch_rate;
      logic [LIMIT_BITS-1:0] pitch_limit;
      logic [DELAY_BITS-1:0] activation_delay;
      logic [STEP_BITS-1:0]  max_step;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      enable:           1'b0,
      yaw_rate:         32'd65536,
      pitch_rate:       32'd65536,
      pitch_limit:      30'd178956970,
      activation_delay: 32'd1000000,
      max_step:         20'd100000
   };

endpackage

// ----- rtl/gis_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gimbal idle scan sequencer channel interfaces
// Request, response and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface gis_req_if import gis_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic                  aim_active;
   logic                  contact;
   logic                  feedback_valid;
   logic [ANGLE_BITS-1:0] yaw_feedback;
   logic [ANGLE_BITS-1:0] pitch_feedback;
   logic [TIME_BITS-1:0]  timestamp_us;

   modport source (
      output valid, aim_active, contact, feedback_valid, yaw_feedback,
             pitch_feedback, timestamp_us,
      input  ready
   );
   modport sink (
      input  valid, aim_active, contact, feedback_valid, yaw_feedback,
             pitch_feedback, timestamp_us,
      output ready
   );
   modport monitor (
      input valid, ready, aim_active, contact, feedback_valid, yaw_feedback,
            pitch_feedback, timestamp_us
   );
endinterface

interface gis_rsp_if import gis_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic                  command_valid;
   logic [ANGLE_BITS-1:0] yaw_target;
   logic [ANGLE_BITS-1:0] pitch_target;
   logic [ANGLE_BITS-1:0] yaw_error;
   logic [ANGLE_BITS-1:0] pitch_error;
   logic [RATE_BITS-1:0]  yaw_speed;
   logic [SPEED_BITS-1:0] pitch_speed;

   modport source (
      output valid, command_valid, yaw_target, pitch_target, yaw_error,
             pitch_error, yaw_speed, pitch_speed,
      input  ready
   );
   modport sink (
      input  valid, command_valid, yaw_target, pitch_target, yaw_error,
             pitch_error, yaw_speed, pitch_speed,
      output ready
   );
   modport monitor (
      input valid, ready, command_valid, yaw_target, pitch_target, yaw_error,
            pitch_error, yaw_speed, pitch_speed
   );
endinterface

interface gis_csr_if import gis_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
   modport monitor (input valid, ready, index, data);
endinterface

// ----- rtl/gis_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gimbal idle scan sequencer register file
// Holds the six configuration registers written over the register channel.
// ----------------------------------------------------------------------------
module gis_csr import gis_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   gis_csr_if.sink csr_ch,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_ENABLE:      cfg_in.enable           = csr_ch.data[0];
            CSR_YAW_RATE:    cfg_in.yaw_rate         = csr_ch.data[RATE_BITS-1:0];
            CSR_PITCH_RATE:  cfg_in.pitch_rate       = csr_ch.data[RATE_BITS-1:0];
            CSR_PITCH_LIMIT: cfg_in.pitch_limit      = csr_ch.data[LIMIT_BITS-1:0];
            CSR_ACT_DELAY:   cfg_in.activation_delay = csr_ch.data[DELAY_BITS-1:0];
            CSR_MAX_STEP:    cfg_in.max_step         = csr_ch.data[STEP_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/gis_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gimbal idle scan sequencer core
// Input register, scan state and the single-pass step computation.
// ----------------------------------------------------------------------------
module gis_core import gis_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   gis_req_if.sink               req_ch,
   output logic                  res_valid,
   input  logic                  res_ready,
   output logic                  res_command_valid,
   output logic [ANGLE_BITS-1:0] res_yaw_target,
   output logic [ANGLE_BITS-1:0] res_pitch_target,
   output logic [ANGLE_BITS-1:0] res_yaw_error,
   output logic [ANGLE_BITS-1:0] res_pitch_error,
   output logic [RATE_BITS-1:0]  res_yaw_speed,
   output logic [SPEED_BITS-1:0] res_pitch_speed
);

   localparam int CW = (TIME_BITS > DELAY_BITS) ? TIME_BITS : DELAY_BITS;
   localparam int SW = (TIME_BITS > STEP_BITS) ? TIME_BITS : STEP_BITS;
   localparam int MW = RATE_BITS + STEP_BITS;
   localparam int DW = MW - FRAC_BITS;
   localparam int PW = ((ANGLE_BITS > DW) ? ANGLE_BITS : DW) + 2;

   logic                  in_valid_ff;
   logic                  aim_ff;
   logic                  contact_ff;
   logic                  fbv_ff;
   logic [ANGLE_BITS-1:0] yfb_ff;
   logic [ANGLE_BITS-1:0] pfb_ff;
   logic [TIME_BITS-1:0]  now_ff;

   logic                  scan_on_ff, scan_on_in;
   logic                  pitch_down_ff, pitch_down_in;
   logic                  idle_started_ff, idle_started_in;
   logic [ANGLE_BITS-1:0] yaw_goal_ff, yaw_goal_in;
   logic [ANGLE_BITS-1:0] pitch_goal_ff, pitch_goal_in;
   logic [TIME_BITS-1:0]  idle_since_ff, idle_since_in;
   logic [TIME_BITS-1:0]  last_step_ff, last_step_in;

   logic                  advance;

   logic [TIME_BITS-1:0]  since;
   logic [TIME_BITS-1:0]  elapsed;
   logic [TIME_BITS-1:0]  last0;
   logic [TIME_BITS-1:0]  dt_raw;
   logic [SW-1:0]         dt_ext;
   logic [STEP_BITS-1:0]  dt;
   logic [MW-1:0]         yprod;
   logic [MW-1:0]         pprod;
   logic [DW-1:0]         ydelta;
   logic [DW-1:0]         pdelta;
   logic [ANGLE_BITS-1:0] base_y;
   logic [ANGLE_BITS-1:0] base_p;
   logic signed [PW-1:0]  p, q, lim_w, pd_w, ang_hi, ang_lo, perr;
   logic                  dir0, dir1, above, below, wait_delay, cmd;

   assign advance      = in_valid_ff && res_ready;
   assign req_ch.ready = !in_valid_ff || res_ready;
   assign res_valid    = in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         aim_ff     <= req_ch.aim_active;
         contact_ff <= req_ch.contact;
         fbv_ff     <= req_ch.feedback_valid;
         yfb_ff     <= req_ch.yaw_feedback;
         pfb_ff     <= req_ch.pitch_feedback;
         now_ff     <= req_ch.timestamp_us;
      end
   end

   assign lim_w  = PW'(cfg.pitch_limit);
   assign ang_hi = PW'({1'b0, {(ANGLE_BITS-1){1'b1}}});
   assign ang_lo = -ang_hi - PW'(1);

   always_comb begin
      scan_on_in      = scan_on_ff;
      pitch_down_in   = pitch_down_ff;
      idle_started_in = idle_started_ff;
      yaw_goal_in     = yaw_goal_ff;
      pitch_goal_in   = pitch_goal_ff;
      idle_since_in   = idle_since_ff;
      last_step_in    = last_step_ff;
      cmd             = 1'b0;
      res_yaw_speed   = '0;
      res_pitch_speed = '0;

      since      = idle_started_ff ? idle_since_ff : now_ff;
      elapsed    = now_ff - since;
      wait_delay = elapsed[TIME_BITS-1] || (CW'(elapsed) < CW'(cfg.activation_delay));

      base_y = scan_on_ff ? yaw_goal_ff : yfb_ff;
      base_p = scan_on_ff ? pitch_goal_ff : pfb_ff;
      last0  = scan_on_ff ? last_step_ff : now_ff;
      dt_raw = now_ff - last0;
      dt_ext = dt_raw[TIME_BITS-1] ? '0 : SW'(dt_raw);
      dt     = (dt_ext > SW'(cfg.max_step)) ? cfg.max_step : dt_ext[STEP_BITS-1:0];

      yprod  = MW'(cfg.yaw_rate) * MW'(dt);
      pprod  = MW'(cfg.pitch_rate) * MW'(dt);
      ydelta = yprod[MW-1:FRAC_BITS];
      pdelta = pprod[MW-1:FRAC_BITS];
      pd_w   = PW'(pdelta);

      p     = PW'($signed(base_p));
      dir0  = scan_on_ff ? pitch_down_ff : !(p < -lim_w);
      above = p > lim_w;
      below = p < -lim_w;
      dir1  = above ? 1'b1 : (below ? 1'b0 : dir0);
      q     = dir1 ? (p - pd_w) : (p + pd_w);
      if (q > ang_hi) begin
         q = ang_hi;
      end else if (q < ang_lo) begin
         q = ang_lo;
      end
      if (!(above || below)) begin
         if (q >= lim_w) begin
            q    = lim_w;
            dir1 = 1'b1;
         end else if (q <= -lim_w) begin
            q    = -lim_w;
            dir1 = 1'b0;
         end
         if (q > ang_hi) begin
            q = ang_hi;
         end else if (q < ang_lo) begin
            q = ang_lo;
         end
      end

      if (!cfg.enable || aim_ff || !fbv_ff) begin
         scan_on_in      = 1'b0;
         pitch_down_in   = 1'b1;
         idle_started_in = 1'b0;
         yaw_goal_in     = '0;
         pitch_goal_in   = '0;
         idle_since_in   = '0;
         last_step_in    = '0;
      end else if (contact_ff) begin
         scan_on_in      = 1'b0;
         idle_started_in = 1'b0;
         yaw_goal_in     = yfb_ff;
         pitch_goal_in   = pfb_ff;
         idle_since_in   = '0;
         last_step_in    = now_ff;
         cmd             = 1'b1;
      end else if (wait_delay) begin
         scan_on_in      = 1'b0;
         idle_started_in = 1'b1;
         idle_since_in   = since;
         yaw_goal_in     = yfb_ff;
         pitch_goal_in   = pfb_ff;
         last_step_in    = now_ff;
      end else begin
         scan_on_in      = 1'b1;
         idle_started_in = 1'b1;
         idle_since_in   = since;
         last_step_in    = now_ff;
         yaw_goal_in     = base_y + ANGLE_BITS'(ydelta);
         pitch_goal_in   = q[ANGLE_BITS-1:0];
         pitch_down_in   = dir1;
         cmd             = 1'b1;
         res_yaw_speed   = cfg.yaw_rate;
         res_pitch_speed = dir1 ? (SPEED_BITS'(0) - SPEED_BITS'(cfg.pitch_rate))
                                : SPEED_BITS'(cfg.pitch_rate);
      end

      perr = PW'($signed(pitch_goal_in)) - PW'($signed(pfb_ff));
      if (perr > ang_hi) begin
         perr = ang_hi;
      end else if (perr < ang_lo) begin
         perr = ang_lo;
      end

      res_command_valid = cmd;
      res_yaw_target    = cmd ? yaw_goal_in : '0;
      res_pitch_target  = cmd ? pitch_goal_in : '0;
      res_yaw_error     = cmd ? (yaw_goal_in - yfb_ff) : '0;
      res_pitch_error   = cmd ? perr[ANGLE_BITS-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_on_ff      <= 1'b0;
         pitch_down_ff   <= 1'b1;
         idle_started_ff <= 1'b0;
         yaw_goal_ff     <= '0;
         pitch_goal_ff   <= '0;
         idle_since_ff   <= '0;
         last_step_ff    <= '0;
      end else if (advance) begin
         scan_on_ff      <= scan_on_in;
         pitch_down_ff   <= pitch_down_in;
         idle_started_ff <= idle_started_in;
         yaw_goal_ff     <= yaw_goal_in;
         pitch_goal_ff   <= pitch_goal_in;
         idle_since_ff   <= idle_since_in;
         last_step_ff    <= last_step_in;
      end
   end

endmodule

// ----- rtl/gis_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gimbal idle scan sequencer result register
// Holds one finished result word until the response channel takes it.
// ----------------------------------------------------------------------------
module gis_out_stage import gis_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  res_valid,
   output logic                  res_ready,
   input  logic                  res_command_valid,
   input  logic [ANGLE_BITS-1:0] res_yaw_target,
   input  logic [ANGLE_BITS-1:0] res_pitch_target,
   input  logic [ANGLE_BITS-1:0] res_yaw_error,
   input  logic [ANGLE_BITS-1:0] res_pitch_error,
   input  logic [RATE_BITS-1:0]  res_yaw_speed,
   input  logic [SPEED_BITS-1:0] res_pitch_speed,
   gis_rsp_if.source             rsp_ch
);

   logic                  valid_ff;
   logic                  cmd_ff;
   logic [ANGLE_BITS-1:0] yaw_target_ff;
   logic [ANGLE_BITS-1:0] pitch_target_ff;
   logic [ANGLE_BITS-1:0] yaw_error_ff;
   logic [ANGLE_BITS-1:0] pitch_error_ff;
   logic [RATE_BITS-1:0]  yaw_speed_ff;
   logic [SPEED_BITS-1:0] pitch_speed_ff;

   assign res_ready = !valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_ready) begin
         valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         cmd_ff          <= res_command_valid;
         yaw_target_ff   <= res_yaw_target;
         pitch_target_ff <= res_pitch_target;
         yaw_error_ff    <= res_yaw_error;
         pitch_error_ff  <= res_pitch_error;
         yaw_speed_ff    <= res_yaw_speed;
         pitch_speed_ff  <= res_pitch_speed;
      end
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.command_valid = cmd_ff;
   assign rsp_ch.yaw_target    = yaw_target_ff;
   assign rsp_ch.pitch_target  = pitch_target_ff;
   assign rsp_ch.yaw_error     = yaw_error_ff;
   assign rsp_ch.pitch_error   = pitch_error_ff;
   assign rsp_ch.yaw_speed     = yaw_speed_ff;
   assign rsp_ch.pitch_speed   = pitch_speed_ff;

endmodule

// ----- rtl/gimbal_idle_scan_sequencer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gimbal idle scan sequencer
// Holds or sweeps the gimbal aim while no target is tracked.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word
//  req_ch   in   flags, yaw/pitch feedback, microsecond timestamp
//  rsp_ch   out  command flag, targets, errors, yaw and pitch speeds
//  csr_ch   in   register index and write data, always ready
//
// One word is taken per cycle while the response side is not stalled; a result
// passes from the input register into the result register before it leaves.
// The scan state updates when a word moves from the input register into the
// result register, so each word sees the state the previous word left.
// Synchronous reset clears the valid flags and scan state and loads CFG_RESET.
// Once both registers hold a word, a stalled response drops req ready in the
// same cycle; at most two words wait inside the block.
// ----------------------------------------------------------------------------
module gimbal_idle_scan_sequencer_top import gis_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF,
   parameter int TIME_BITS  = TIME_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   gis_req_if.sink   req_ch,
   gis_rsp_if.source rsp_ch,
   gis_csr_if.sink   csr_ch
);

   cfg_type               cfg;
   logic                  res_valid;
   logic                  res_ready;
   logic                  res_command_valid;
   logic [ANGLE_BITS-1:0] res_yaw_target;
   logic [ANGLE_BITS-1:0] res_pitch_target;
   logic [ANGLE_BITS-1:0] res_yaw_error;
   logic [ANGLE_BITS-1:0] res_pitch_error;
   logic [RATE_BITS-1:0]  res_yaw_speed;
   logic [SPEED_BITS-1:0] res_pitch_speed;

   gis_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   gis_core #(
      .ANGLE_BITS (ANGLE_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_ch            (req_ch),
      .res_valid         (res_valid),
      .res_ready         (res_ready),
      .res_command_valid (res_command_valid),
      .res_yaw_target    (res_yaw_target),
      .res_pitch_target  (res_pitch_target),
      .res_yaw_error     (res_yaw_error),
      .res_pitch_error   (res_pitch_error),
      .res_yaw_speed     (res_yaw_speed),
      .res_pitch_speed   (res_pitch_speed)
   );

   gis_out_stage #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_out (
      .clock             (clock),
      .reset             (reset),
      .res_valid         (res_valid),
      .res_ready         (res_ready),
      .res_command_valid (res_command_valid),
      .res_yaw_target    (res_yaw_target),
      .res_pitch_target  (res_pitch_target),
      .res_yaw_error     (res_yaw_error),
      .res_pitch_error   (res_pitch_error),
      .res_yaw_speed     (res_yaw_speed),
      .res_pitch_speed   (res_pitch_speed),
      .rsp_ch            (rsp_ch)
   );

endmodule

// ----- rtl/gis_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gimbal idle scan sequencer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module gis_checker import gis_pkg::*; (
   input logic       clock,
   input logic       reset,
   gis_req_if.sink   req_ch,
   gis_rsp_if.source rsp_ch,
   gis_csr_if.sink   csr_ch
);

   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid)
      else $error("Response word dropped while stalled.");

   a_rsp_word_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=>
         $stable(rsp_ch.command_valid) && $stable(rsp_ch.yaw_target) &&
         $stable(rsp_ch.pitch_target) && $stable(rsp_ch.yaw_error) &&
         $stable(rsp_ch.pitch_error) && $stable(rsp_ch.yaw_speed) &&
         $stable(rsp_ch.pitch_speed))
      else $error("Response word changed while stalled.");

   a_no_command_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.command_valid |->
         rsp_ch.yaw_target == '0 && rsp_ch.pitch_target == '0 &&
         rsp_ch.yaw_error == '0 && rsp_ch.pitch_error == '0 &&
         rsp_ch.yaw_speed == '0 && rsp_ch.pitch_speed == '0)
      else $error("Word without a command carries nonzero fields.");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready &&
      $past(rsp_ch.valid && !rsp_ch.ready) && $past(req_ch.valid && req_ch.ready)
         |-> !req_ch.ready && csr_ch.ready)
      else $error("Request taken with both registers full.");

endmodule

bind gimbal_idle_scan_sequencer_top gis_checker u_gis_checker (
   .clock  (clock),
   .reset  (reset),
   .req_ch (req_ch),
   .rsp_ch (rsp_ch),
   .csr_ch (csr_ch)
);

// ----- bench/tb_gimbal_idle_scan_sequencer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gimbal idle scan sequencer testbench
// Drives request words through the block and checks every response word
// against an in-bench prediction of the hold, wait and scan behavior. Register
// settings change between bursts, once the block has drained, and the run
// steps through phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_gimbal_idle_scan_sequencer_top import gis_pkg::*; ;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int BURSTS       = 5;
   localparam int BURST_WORDS  = 45;
   localparam longint ANG_MAX  = 64'sd2147483647;
   localparam longint ANG_MIN  = -64'sd2147483648;

   typedef struct {
      bit        aim;
      bit        contact;
      bit        fb_ok;
      bit [31:0] yaw_fb;
      bit [31:0] pitch_fb;
      bit [31:0] now;
   } req_word_type;

   typedef struct {
      logic        cmd;
      logic [31:0] yaw_target;
      logic [31:0] pitch_target;
      logic [31:0] yaw_error;
      logic [31:0] pitch_error;
      logic [31:0] yaw_speed;
      logic [32:0] pitch_speed;
   } rsp_word_type;

   class scan_scoreboard;
      cfg_type      regs;
      bit           scan_on, pitch_down, idle_started;
      bit [31:0]    yaw_goal, pitch_goal, idle_since, last_step;
      rsp_word_type expected_cmds[$];
      int           errors;
      int           checked;

      function new();
         regs = CFG_RESET;
         clear_scan();
      endfunction

      function void clear_scan();
         scan_on = 0;
         pitch_down = 1;
         yaw_goal = 0;
         pitch_goal = 0;
         idle_started = 0;
         idle_since = 0;
         last_step = 0;
      endfunction

      function void set_reg(csr_index_type idx, bit [31:0] v);
         case (idx)
            CSR_ENABLE:      regs.enable = v[0];
            CSR_YAW_RATE:    regs.yaw_rate = v;
            CSR_PITCH_RATE:  regs.pitch_rate = v;
            CSR_PITCH_LIMIT: regs.pitch_limit = v[LIMIT_BITS-1:0];
            CSR_ACT_DELAY:   regs.activation_delay = v;
            CSR_MAX_STEP:    regs.max_step = v[STEP_BITS-1:0];
            default: ;
         endcase
      endfunction

      function longint sat_angle(longint v);
         if (v > ANG_MAX) return ANG_MAX;
         if (v < ANG_MIN) return ANG_MIN;
         return v;
      endfunction

      function rsp_word_type command(req_word_type w, bit [31:0] yspd, bit [32:0] pspd);
         rsp_word_type r;
         r.cmd = 1'b1;
         r.yaw_target = yaw_goal;
         r.pitch_target = pitch_goal;
         r.yaw_error = yaw_goal - w.yaw_fb;
         r.pitch_error = 32'(sat_angle(longint'($signed(pitch_goal))
                                       - longint'($signed(w.pitch_fb))));
         r.yaw_speed = yspd;
         r.pitch_speed = pspd;
         return r;
      endfunction

      function rsp_word_type predict_command(req_word_type w);
         rsp_word_type r;
         longint       pfb, lim, p;
         bit [31:0]    d, dt;
         bit [63:0]    ydelta, pdelta;
         bit           outside;
         bit [32:0]    pspd;
         r = '{cmd: 1'b0, yaw_target: '0, pitch_target: '0, yaw_error: '0,
               pitch_error: '0, yaw_speed: '0, pitch_speed: '0};
         pfb = longint'($signed(w.pitch_fb));
         lim = longint'(regs.pitch_limit);
         if (!regs.enable || w.aim || !w.fb_ok) begin
            clear_scan();
            return r;
         end
         if (w.contact) begin
            yaw_goal = w.yaw_fb;
            pitch_goal = w.pitch_fb;
            scan_on = 0;
            idle_started = 0;
            idle_since = 0;
            last_step = w.now;
            return command(w, 32'd0, 33'd0);
         end
         if (!idle_started) begin
            idle_started = 1;
            idle_since = w.now;
         end
         d = w.now - idle_since;
         if (d[31] || d < regs.activation_delay) begin
            scan_on = 0;
            yaw_goal = w.yaw_fb;
            pitch_goal = w.pitch_fb;
            last_step = w.now;
            return r;
         end
         if (!scan_on) begin
            yaw_goal = w.yaw_fb;
            pitch_goal = w.pitch_fb;
            pitch_down = !(pfb < -lim);
            last_step = w.now;
            scan_on = 1;
         end
         dt = w.now - last_step;
         if (dt[31]) dt = 0;
         if (dt > 32'(regs.max_step)) dt = 32'(regs.max_step);
         last_step = w.now;
         ydelta = (64'(regs.yaw_rate) * 64'(dt)) >> FRAC_BITS;
         pdelta = (64'(regs.pitch_rate) * 64'(dt)) >> FRAC_BITS;
         yaw_goal = yaw_goal + ydelta[31:0];
         p = longint'($signed(pitch_goal));
         outside = (p > lim) || (p < -lim);
         if (p > lim) pitch_down = 1;
         else if (p < -lim) pitch_down = 0;
         p = sat_angle(pitch_down ? p - longint'(pdelta) : p + longint'(pdelta));
         if (!outside) begin
            if (p >= lim) begin
               p = lim;
               pitch_down = 1;
            end else if (p <= -lim) begin
               p = -lim;
               pitch_down = 0;
            end
         end
         pitch_goal = 32'(p);
         pspd = pitch_down ? 33'd0 - {1'b0, regs.pitch_rate} : {1'b0, regs.pitch_rate};
         return command(w, regs.yaw_rate, pspd);
      endfunction

      function void note_req(req_word_type w);
         expected_cmds.push_back(predict_command(w));
      endfunction

      function int pending();
         return expected_cmds.size();
      endfunction

      function void check_field(string name, logic [32:0] exp_v, logic [32:0] got_v);
         if (got_v !== exp_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
         end
      endfunction

      function void check_rsp(rsp_word_type got);
         rsp_word_type exp_r;
         if (expected_cmds.size() == 0) begin
            errors++;
            $display("%0t: response word with nothing expected, actual yaw_target %h",
                     $time, got.yaw_target);
            return;
         end
         exp_r = expected_cmds.pop_front();
         checked++;
         check_field("command_valid", 33'(exp_r.cmd), 33'(got.cmd));
         check_field("yaw_target", 33'(exp_r.yaw_target), 33'(got.yaw_target));
         check_field("pitch_target", 33'(exp_r.pitch_target), 33'(got.pitch_target));
         check_field("yaw_error", 33'(exp_r.yaw_error), 33'(got.yaw_error));
         check_field("pitch_error", 33'(exp_r.pitch_error), 33'(got.pitch_error));
         check_field("yaw_speed", 33'(exp_r.yaw_speed), 33'(got.yaw_speed));
         check_field("pitch_speed", exp_r.pitch_speed, got.pitch_speed);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   gis_req_if req_ch ();
   gis_rsp_if rsp_ch ();
   gis_csr_if csr_ch ();

   gimbal_idle_scan_sequencer_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   scan_scoreboard sb = new();
   int        send_idle_pct;
   int        recv_stall_pct;
   int        cycles;
   int        words_sent;
   int        settings;
   bit [31:0] now_us;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_gimbal_idle_scan_sequencer_top: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_word_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.cmd = rsp_ch.command_valid;
         got.yaw_target = rsp_ch.yaw_target;
         got.pitch_target = rsp_ch.pitch_target;
         got.yaw_error = rsp_ch.yaw_error;
         got.pitch_error = rsp_ch.pitch_error;
         got.yaw_speed = rsp_ch.yaw_speed;
         got.pitch_speed = rsp_ch.pitch_speed;
         sb.check_rsp(got);
      end
   end

   task automatic send_word(req_word_type w);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.aim_active <= w.aim;
      req_ch.contact <= w.contact;
      req_ch.feedback_valid <= w.fb_ok;
      req_ch.yaw_feedback <= w.yaw_fb;
      req_ch.pitch_feedback <= w.pitch_fb;
      req_ch.timestamp_us <= w.now;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_req(w);
      words_sent++;
   endtask

   task automatic send_fields(bit aim, bit contact, bit fb_ok, bit [31:0] yfb,
                              bit [31:0] pfb, bit [31:0] t);
      req_word_type w;
      w = '{aim: aim, contact: contact, fb_ok: fb_ok, yaw_fb: yfb, pitch_fb: pfb, now: t};
      send_word(w);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, bit [31:0] v);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= v;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      sb.set_reg(idx, v);
   endtask

   task automatic configure(cfg_type c);
      drain();
      write_reg(CSR_ENABLE, 32'(c.enable));
      write_reg(CSR_YAW_RATE, c.yaw_rate);
      write_reg(CSR_PITCH_RATE, c.pitch_rate);
      write_reg(CSR_PITCH_LIMIT, 32'(c.pitch_limit));
      write_reg(CSR_ACT_DELAY, c.activation_delay);
      write_reg(CSR_MAX_STEP, 32'(c.max_step));
      csr_ch.valid <= 1'b0;
      settings++;
   endtask

   function automatic bit [31:0] pick_rate();
      case ($urandom_range(3))
         0: return 32'd1;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(32'd1 << 20, 1);
         default: return $urandom() | 32'd1;
      endcase
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.enable = ($urandom_range(9) != 0);
      c.yaw_rate = pick_rate();
      c.pitch_rate = pick_rate();
      case ($urandom_range(3))
         0: c.pitch_limit = 30'd1;
         1: c.pitch_limit = 30'h3FFF_FFFF;
         2: c.pitch_limit = 30'($urandom_range(32'h3FFF_FFFF, 1));
         default: c.pitch_limit = 30'($urandom_range(32'd1 << 20, 1));
      endcase
      case ($urandom_range(3))
         0: c.max_step = 20'd1;
         1: c.max_step = 20'hF_FFFF;
         2: c.max_step = 20'($urandom_range(2000, 1));
         default: c.max_step = 20'($urandom_range(32'hF_FFFF, 1));
      endcase
      case ($urandom_range(9))
         0, 1: c.activation_delay = 32'd0;
         2: c.activation_delay = 32'h7FFF_FFFF;
         3: c.activation_delay = 32'h8000_0000;
         4: c.activation_delay = $urandom();
         default: c.activation_delay = $urandom_range(4 * 32'(c.max_step), 0);
      endcase
      return c;
   endfunction

   function automatic req_word_type scan_word(cfg_type c);
      req_word_type w;
      int           k;
      bit [31:0]    lim, s, u;
      lim = 32'(c.pitch_limit);
      s = 32'(c.max_step);
      k = $urandom_range(99);
      w.aim = (k < 3);
      w.fb_ok = !(k >= 3 && k < 6);
      w.contact = (k >= 6 && k < 14);
      if (k >= 97) begin
         w.aim = 1'($urandom_range(1));
         w.contact = 1'($urandom_range(1));
         w.fb_ok = 1'($urandom_range(1));
      end
      case ($urandom_range(19))
         0, 1: now_us = now_us + $urandom_range(3 * s, s);
         2: now_us = now_us - $urandom_range(1000, 1);
         3: now_us = $urandom();
         4: ;
         default: now_us = now_us + $urandom_range(s, 0);
      endcase
      w.now = now_us;
      w.yaw_fb = $urandom();
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            u = $urandom_range(2 * lim, 0);
            w.pitch_fb = u - lim;
         end
         4, 5, 6: w.pitch_fb = $urandom();
         7: w.pitch_fb = $urandom_range(1) ? lim : 32'd0 - lim;
         8: w.pitch_fb = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: w.pitch_fb = $urandom_range(1) ? lim + 1 : 32'd0 - lim - 1;
      endcase
      return w;
   endfunction

   task automatic directed_words();
      cfg_type c;
      send_fields(0, 0, 1, 32'h1234_5678, 32'h0, 32'd5);
      send_fields(1, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      c = '{enable: 1'b1, yaw_rate: 32'hFFFF_FFFF, pitch_rate: 32'hFFFF_FFFF,
            pitch_limit: 30'd1000, activation_delay: 32'd0, max_step: 20'hF_FFFF};
      configure(c);
      send_fields(1, 0, 1, 32'h0, 32'h0, 32'd100);
      send_fields(0, 0, 0, 32'h0, 32'h0, 32'd100);
      send_fields(0, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd100);
      send_fields(0, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd100);
      send_fields(0, 0, 1, 32'h0, 32'h0, 32'd200);
      send_fields(0, 0, 1, 32'h0, 32'h0, 32'd2100000);
      send_fields(0, 0, 1, 32'h0, 32'h0, 32'd2000000);
      send_fields(0, 1, 1, 32'h0, 32'd500, 32'd2000010);
      send_fields(0, 0, 1, 32'h0, 32'd500, 32'd2000020);
      send_fields(0, 0, 1, 32'h0, 32'd500, 32'd2000021);
      send_fields(0, 0, 1, 32'h0, 32'd500, 32'd2000022);

      c = '{enable: 1'b1, yaw_rate: 32'd1, pitch_rate: 32'd1,
            pitch_limit: 30'h3FFF_FFFF, activation_delay: 32'h8000_0000, max_step: 20'd1};
      configure(c);
      send_fields(0, 0, 1, 32'h0, 32'h0, 32'd0);
      send_fields(0, 0, 1, 32'h0, 32'h0, 32'h7FFF_FFFF);
      send_fields(0, 0, 1, 32'h0, 32'h0, 32'hFFFF_FFFF);

      c = '{enable: 1'b1, yaw_rate: 32'h8000_0000, pitch_rate: 32'd65536,
            pitch_limit: 30'h3FFF_FFFF, activation_delay: 32'd10, max_step: 20'd1};
      configure(c);
      send_fields(0, 1, 1, 32'h0, 32'h3FFF_FFFF, 32'hFFFF_FFF0);
      send_fields(0, 0, 1, 32'h0, 32'h3FFF_FFFF, 32'hFFFF_FFF8);
      send_fields(0, 0, 1, 32'h0, 32'h3FFF_FFFF, 32'h0000_0004);
      send_fields(0, 0, 1, 32'h0, 32'h8000_0000, 32'h0000_0009);
   endtask

   initial begin
      cfg_type c;
      int      ph;
      int      b;
      int      i;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.aim_active <= 1'b0;
      req_ch.contact <= 1'b0;
      req_ch.feedback_valid <= 1'b0;
      req_ch.yaw_feedback <= '0;
      req_ch.pitch_feedback <= '0;
      req_ch.timestamp_us <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_ENABLE;
      csr_ch.data <= '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      now_us = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      directed_words();

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         for (b = 0; b < BURSTS; b++) begin
            c = random_cfg();
            configure(c);
            if ($urandom_range(3) == 0) now_us = $urandom();
            for (i = 0; i < BURST_WORDS; i++) send_word(scan_word(c));
         end
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Run covered %0d request words and %0d checked responses", words_sent,
               sb.checked);
      $display("across %0d register settings and four idle/stall phases.", settings);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_gimbal_idle_scan_sequencer_top: done, clean");
      end else begin
         $display("tb_gimbal_idle_scan_sequencer_top: done, errors");
      end
      $finish;
   end

endmodule

// ----- gimbal_idle_scan_sequencer_top.f -----
rtl/gis_pkg.sv
rtl/gis_if.sv
rtl/gis_csr.sv
rtl/gis_core.sv
rtl/gis_out_stage.sv
rtl/gimbal_idle_scan_sequencer_top.sv
rtl/gis_checker.sv
bench/tb_gimbal_idle_scan_sequencer_top.sv
